>>> rtl/length_prefixed_frame_receiver_defines.svh
// assertion macros used by the checker module
`ifndef LENGTH_PREFIXED_FRAME_RECEIVER_DEFINES_SVH
`define LENGTH_PREFIXED_FRAME_RECEIVER_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define LPFR_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define LPFR_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/lpfr_pkg.sv
package lpfr_pkg;

    localparam int BYTE_W    = 8;
    localparam int CFG_IDX_W = 8;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_START_BYTE = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_END_BYTE   = 8'd1;

    // register reset values
    localparam logic [BYTE_W-1:0] START_BYTE_RESET = 8'd2;
    localparam logic [BYTE_W-1:0] END_BYTE_RESET   = 8'd3;

    typedef enum logic [2:0] {
        ST_HUNT,
        ST_LEN,
        ST_DATA,
        ST_END,
        ST_EMIT
    } lpfr_state_t;

    // controller to datapath
    typedef struct packed {
        logic store_len;
        logic store_data;
        logic start_emit;
        logic emit_en;
    } lpfr_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic start_match;
        logic len_ok;
        logic len_zero;
        logic data_done;
        logic end_match;
        logic issue_last;
    } lpfr_status_t;

endpackage

>>> rtl/lpfr_if.sv
// received byte stream
interface lpfr_in_if;
    logic                        valid;
    logic                        ready;
    logic [lpfr_pkg::BYTE_W-1:0] in_byte;

    modport source (output valid, output in_byte, input ready);
    modport sink (input valid, input in_byte, output ready);
endinterface

// emitted frame bytes
interface lpfr_out_if;
    logic                        valid;
    logic                        ready;
    logic [lpfr_pkg::BYTE_W-1:0] out_byte;
    logic                        out_last;

    modport source (output valid, output out_byte, output out_last, input ready);
    modport sink (input valid, input out_byte, input out_last, output ready);
endinterface

// configuration register writes
interface lpfr_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [lpfr_pkg::CFG_IDX_W-1:0] index;
    logic [lpfr_pkg::BYTE_W-1:0]    data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

>>> rtl/length_prefixed_frame_receiver.sv
// length prefixed frame receiver
// link: one received byte per transfer. the block hunts for the start byte,
//   takes a length byte (above MAX_PAYLOAD drops the frame), stores the length
//   byte and that many payload bytes, then checks the end byte.
// frame: on a good end byte the stored length byte and payload are sent as
//   length + 1 transfers, out_last set on the final one.
// cfg: register 0 is the start byte (reset 2), register 1 the end byte
//   (reset 3); ready is always high, other indexes are ignored.
// throughput: one link byte per cycle while a frame is being collected.
//   link ready drops for the emission of a frame, which reads the frame store
//   one entry per cycle while frame is not stalled.
// the end byte transfer moves the block to the emit state, which loads the
//   frame bytes into the output register, one per cycle unless frame stalls.
// link ready returns at the same edge that loads the last byte into the output
//   register, so hunting resumes while that byte waits for frame ready.
// when frame stalls, the output register holds its byte and the emission
//   waits; the link stays stalled until the last byte is loaded.
// reset: hunting, registers at their reset values, output empty.
module length_prefixed_frame_receiver #(
    parameter int MAX_PAYLOAD = 63
) (
    input logic        clk,
    input logic        rst_n,
    lpfr_in_if.sink    link,
    lpfr_out_if.source frame,
    lpfr_cfg_if.sink   cfg
);

    lpfr_pkg::lpfr_cmd_t    cmd;
    lpfr_pkg::lpfr_status_t status;
    logic                   link_ready;
    logic                   in_xfer;
    logic                   cfg_xfer;

    assign link.ready = link_ready;
    assign in_xfer    = link.valid && link_ready;
    assign cfg.ready  = 1'b1;
    assign cfg_xfer   = cfg.valid;

    // control sequencing
    lpfr_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_xfer  (in_xfer),
        .status   (status),
        .cmd      (cmd),
        .in_ready (link_ready)
    );

    // store, pointers and output register
    lpfr_datapath #(
        .MAX_PAYLOAD (MAX_PAYLOAD)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .in_byte   (link.in_byte),
        .cfg_xfer  (cfg_xfer),
        .cfg_index (cfg.index),
        .cfg_data  (cfg.data),
        .out_ready (frame.ready),
        .out_valid (frame.valid),
        .out_byte  (frame.out_byte),
        .out_last  (frame.out_last)
    );

endmodule

>>> rtl/lpfr_ctrl.sv
module lpfr_ctrl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_xfer,
    input  lpfr_pkg::lpfr_status_t status,
    output lpfr_pkg::lpfr_cmd_t    cmd,
    output logic                   in_ready
);

    lpfr_pkg::lpfr_state_t state_reg;
    lpfr_pkg::lpfr_state_t state_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= lpfr_pkg::ST_HUNT;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            lpfr_pkg::ST_HUNT:
            begin
                if (in_xfer && status.start_match)
                begin
                    state_next = lpfr_pkg::ST_LEN;
                end
            end
            lpfr_pkg::ST_LEN:
            begin
                if (in_xfer)
                begin
                    if (!status.len_ok)
                    begin
                        state_next = lpfr_pkg::ST_HUNT;
                    end
                    else if (status.len_zero)
                    begin
                        state_next = lpfr_pkg::ST_END;
                    end
                    else
                    begin
                        state_next = lpfr_pkg::ST_DATA;
                    end
                end
            end
            lpfr_pkg::ST_DATA:
            begin
                if (in_xfer && status.data_done)
                begin
                    state_next = lpfr_pkg::ST_END;
                end
            end
            lpfr_pkg::ST_END:
            begin
                if (in_xfer)
                begin
                    state_next = status.end_match ? lpfr_pkg::ST_EMIT : lpfr_pkg::ST_HUNT;
                end
            end
            lpfr_pkg::ST_EMIT:
            begin
                // leave once the last byte is loaded into the output register
                if (status.issue_last)
                begin
                    state_next = lpfr_pkg::ST_HUNT;
                end
            end
            default:
            begin
                state_next = lpfr_pkg::ST_HUNT;
            end
        endcase
    end

    // outputs
    always_comb
    begin
        cmd      = '0;
        in_ready = 1'b1;
        case (state_reg)
            lpfr_pkg::ST_HUNT:
            begin
                in_ready = 1'b1;
            end
            lpfr_pkg::ST_LEN:
            begin
                cmd.store_len = in_xfer && status.len_ok;
            end
            lpfr_pkg::ST_DATA:
            begin
                cmd.store_data = in_xfer;
            end
            lpfr_pkg::ST_END:
            begin
                cmd.start_emit = in_xfer && status.end_match;
            end
            lpfr_pkg::ST_EMIT:
            begin
                in_ready    = 1'b0;
                cmd.emit_en = 1'b1;
            end
            default:
            begin
                in_ready = 1'b1;
            end
        endcase
    end

endmodule

>>> rtl/lpfr_datapath.sv
module lpfr_datapath #(
    parameter int MAX_PAYLOAD = 63
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  lpfr_pkg::lpfr_cmd_t            cmd,
    output lpfr_pkg::lpfr_status_t         status,
    input  logic [lpfr_pkg::BYTE_W-1:0]    in_byte,
    input  logic                           cfg_xfer,
    input  logic [lpfr_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [lpfr_pkg::BYTE_W-1:0]    cfg_data,
    input  logic                           out_ready,
    output logic                           out_valid,
    output logic [lpfr_pkg::BYTE_W-1:0]    out_byte,
    output logic                           out_last
);

    localparam int DEPTH = MAX_PAYLOAD + 1;
    localparam int IDX_W = $clog2(DEPTH);
    localparam logic [lpfr_pkg::BYTE_W-1:0] MAX_BYTE = lpfr_pkg::BYTE_W'(MAX_PAYLOAD);

    logic [lpfr_pkg::BYTE_W-1:0] start_byte_reg;
    logic [lpfr_pkg::BYTE_W-1:0] end_byte_reg;

    logic [IDX_W-1:0] frame_length_reg;
    logic [IDX_W-1:0] frame_length_next;
    logic [IDX_W-1:0] wr_ptr_reg;
    logic [IDX_W-1:0] wr_ptr_next;
    logic [IDX_W-1:0] rd_ptr_reg;
    logic [IDX_W-1:0] rd_ptr_next;

    logic                        out_valid_reg;
    logic                        out_valid_next;
    logic [lpfr_pkg::BYTE_W-1:0] out_byte_reg;
    logic                        out_last_reg;

    logic [lpfr_pkg::BYTE_W-1:0] mem [DEPTH];
    logic [IDX_W-1:0]            wr_addr;
    logic                        wr_en;
    logic                        can_load;
    logic                        load;

    // configuration registers, writes beyond the list are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_byte_reg <= lpfr_pkg::START_BYTE_RESET;
            end_byte_reg   <= lpfr_pkg::END_BYTE_RESET;
        end
        else if (cfg_xfer)
        begin
            case (cfg_index)
                lpfr_pkg::REG_START_BYTE: start_byte_reg <= cfg_data;
                lpfr_pkg::REG_END_BYTE:   end_byte_reg   <= cfg_data;
                default:                  start_byte_reg <= start_byte_reg;
            endcase
        end
    end

    // output register takes a new byte when empty or being drained
    assign can_load = !out_valid_reg || out_ready;
    assign load     = cmd.emit_en && can_load;

    // status toward the controller
    always_comb
    begin
        status.start_match = (in_byte == start_byte_reg);
        status.len_ok      = (in_byte <= MAX_BYTE);
        status.len_zero    = (in_byte == '0);
        status.data_done   = (wr_ptr_reg == frame_length_reg);
        status.end_match   = (in_byte == end_byte_reg);
        status.issue_last  = can_load && (rd_ptr_reg == frame_length_reg);
    end

    // length, write and read pointers
    always_comb
    begin
        frame_length_next = frame_length_reg;
        wr_ptr_next       = wr_ptr_reg;
        rd_ptr_next       = rd_ptr_reg;
        if (cmd.store_len)
        begin
            frame_length_next = in_byte[IDX_W-1:0];
            wr_ptr_next       = IDX_W'(1);
        end
        else if (cmd.store_data)
        begin
            wr_ptr_next = wr_ptr_reg + IDX_W'(1);
        end
        if (cmd.start_emit)
        begin
            rd_ptr_next = '0;
        end
        else if (load)
        begin
            rd_ptr_next = rd_ptr_reg + IDX_W'(1);
        end
    end

    // output valid flag
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_length_reg <= '0;
            wr_ptr_reg       <= '0;
            rd_ptr_reg       <= '0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            frame_length_reg <= frame_length_next;
            wr_ptr_reg       <= wr_ptr_next;
            rd_ptr_reg       <= rd_ptr_next;
            out_valid_reg    <= out_valid_next;
        end
    end

    // frame store write, length byte at entry zero
    assign wr_en   = cmd.store_len || cmd.store_data;
    assign wr_addr = cmd.store_len ? '0 : wr_ptr_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= in_byte;
        end
    end

    // registered read doubles as the output register
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out_byte_reg <= mem[rd_ptr_reg];
            out_last_reg <= (rd_ptr_reg == frame_length_reg);
        end
    end

    assign out_valid = out_valid_reg;
    assign out_byte  = out_byte_reg;
    assign out_last  = out_last_reg;

endmodule

>>> rtl/lpfr_checker.sv
`include "length_prefixed_frame_receiver_defines.svh"

module lpfr_checker (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        link_ready,
    input logic                        frame_valid,
    input logic                        frame_ready,
    input logic [lpfr_pkg::BYTE_W-1:0] frame_byte,
    input logic                        frame_last,
    input logic                        cfg_ready
);

    // a stalled frame byte holds
    `LPFR_ASSERT_NEXT(a_frame_hold, frame_valid && !frame_ready, frame_valid && $stable(frame_byte) && $stable(frame_last), "frame byte changed while stalled")

    // while the link is stalled a frame is being emitted
    `LPFR_ASSERT_NEXT(a_stall_emits, !link_ready, frame_valid, "link stalled without frame output")

    // the register port never back-pressures
    `LPFR_ASSERT_NOW(a_cfg_ready, 1'b1, cfg_ready, "cfg ready dropped")

endmodule

bind length_prefixed_frame_receiver lpfr_checker u_lpfr_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .link_ready  (link.ready),
    .frame_valid (frame.valid),
    .frame_ready (frame.ready),
    .frame_byte  (frame.out_byte),
    .frame_last  (frame.out_last),
    .cfg_ready   (cfg.ready)
);

>>> tb/length_prefixed_frame_receiver_tb.sv
`timescale 1ns / 100ps

module length_prefixed_frame_receiver_tb;

    localparam int MAX_PAYLOAD  = 63;
    localparam int CLK_HALF     = 6;
    localparam int DRAIN_CYCLES = 16;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int PHASE_BYTES  = 16;

    typedef logic [lpfr_pkg::BYTE_W-1:0]    byte_t;
    typedef logic [lpfr_pkg::CFG_IDX_W-1:0] cfg_idx_t;

    typedef struct {
        logic [lpfr_pkg::BYTE_W-1:0] data;
        logic                        last;
    } frame_byte_t;

    // tracks the parser state and the frame bytes still owed by the block
    class frame_scoreboard;
        logic [lpfr_pkg::BYTE_W-1:0] start_byte     = lpfr_pkg::START_BYTE_RESET;
        logic [lpfr_pkg::BYTE_W-1:0] end_byte       = lpfr_pkg::END_BYTE_RESET;
        lpfr_pkg::lpfr_state_t       phase          = lpfr_pkg::ST_HUNT;
        logic [5:0]                  frame_length   = '0;
        logic [6:0]                  bytes_stored   = '0;
        logic [lpfr_pkg::BYTE_W-1:0] frame_store [64];
        frame_byte_t                 owed_bytes [$];
        int                          error_count    = 0;
        int                          frames_checked = 0;
        int                          bytes_checked  = 0;

        function void note_register(logic [lpfr_pkg::CFG_IDX_W-1:0] idx,
                                    logic [lpfr_pkg::BYTE_W-1:0] val);
            if (idx == lpfr_pkg::REG_START_BYTE)
                start_byte = val;
            else if (idx == lpfr_pkg::REG_END_BYTE)
                end_byte = val;
        endfunction

        function void back_to_hunting();
            phase        = lpfr_pkg::ST_HUNT;
            frame_length = '0;
            bytes_stored = '0;
        endfunction

        // one accepted link byte
        function void note_link_byte(logic [lpfr_pkg::BYTE_W-1:0] b);
            frame_byte_t fb;
            case (phase)
                lpfr_pkg::ST_HUNT:
                begin
                    if (b == start_byte)
                        phase = lpfr_pkg::ST_LEN;
                end
                lpfr_pkg::ST_LEN:
                begin
                    if (b > MAX_PAYLOAD)
                        back_to_hunting();
                    else
                    begin
                        frame_length   = b[5:0];
                        frame_store[0] = b;
                        bytes_stored   = 7'd1;
                        phase          = (b == 0) ? lpfr_pkg::ST_END : lpfr_pkg::ST_DATA;
                    end
                end
                lpfr_pkg::ST_DATA:
                begin
                    frame_store[bytes_stored[5:0]] = b;
                    bytes_stored = bytes_stored + 7'd1;
                    if (bytes_stored > frame_length)
                        phase = lpfr_pkg::ST_END;
                end
                default:
                begin
                    // good end byte releases the stored frame
                    if (b == end_byte)
                    begin
                        for (int i = 0; i <= frame_length; i++)
                        begin
                            fb.data = frame_store[i];
                            fb.last = (i == frame_length);
                            owed_bytes.push_back(fb);
                        end
                    end
                    back_to_hunting();
                end
            endcase
        endfunction

        // one accepted frame byte against the oldest owed one
        function void check_frame_byte(logic [lpfr_pkg::BYTE_W-1:0] b, logic last);
            frame_byte_t fb;
            if (owed_bytes.size() == 0)
            begin
                $error("unexpected frame byte: out_byte %0h out_last %0b", b, last);
                error_count++;
            end
            else
            begin
                fb = owed_bytes.pop_front();
                bytes_checked++;
                if (last)
                    frames_checked++;
                if (b !== fb.data)
                begin
                    $error("out_byte mismatch: expected %0h, actual %0h", fb.data, b);
                    error_count++;
                end
                if (last !== fb.last)
                begin
                    $error("out_last mismatch: expected %0b, actual %0b", fb.last, last);
                    error_count++;
                end
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;
    int   tx_idle_pct;
    int   rx_idle_pct;
    int   link_bytes_sent;
    int   settings_used;
    int   cycle_count;

    frame_scoreboard frame_model;

    lpfr_in_if  link_if ();
    lpfr_out_if frame_if ();
    lpfr_cfg_if cfg_if ();

    length_prefixed_frame_receiver #(
        .MAX_PAYLOAD (MAX_PAYLOAD)
    ) u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .link  (link_if.sink),
        .frame (frame_if.source),
        .cfg   (cfg_if.sink)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #CLK_HALF clk = ~clk;
    end

    // frame side ready with random stalls
    initial
    begin
        forever
        begin
            @(posedge clk);
            frame_if.ready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    // frame side monitor, sampled mid-cycle so the handshake is settled
    always @(negedge clk)
    begin
        if (rst_n && frame_if.valid && frame_if.ready)
            frame_model.check_frame_byte(frame_if.out_byte, frame_if.out_last);
    end

    // run limit
    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("status: fail");
        $finish;
    end

    // one link transfer, with random idle cycles ahead of it
    task automatic send_byte(input logic [lpfr_pkg::BYTE_W-1:0] b);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            link_if.valid <= 1'b0;
            @(posedge clk);
        end
        link_if.valid   <= 1'b1;
        link_if.in_byte <= b;
        do @(negedge clk); while (!link_if.ready);
        frame_model.note_link_byte(b);
        link_bytes_sent++;
        @(posedge clk);
    endtask

    // hold the link until every owed frame byte is out, then let the block settle
    task automatic settle_link();
        link_if.valid <= 1'b0;
        do @(posedge clk); while (frame_model.owed_bytes.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // framing registers plus one write to an index that does not exist
    task automatic write_framing(input logic [lpfr_pkg::BYTE_W-1:0] s,
                                 input logic [lpfr_pkg::BYTE_W-1:0] e);
        logic [lpfr_pkg::CFG_IDX_W-1:0] idx [3];
        logic [lpfr_pkg::BYTE_W-1:0]    val [3];
        idx[0] = lpfr_pkg::REG_START_BYTE;
        val[0] = s;
        idx[1] = cfg_idx_t'($urandom_range(lpfr_pkg::REG_END_BYTE + 1,
                                           (1 << lpfr_pkg::CFG_IDX_W) - 1));
        val[1] = byte_t'($urandom_range((1 << lpfr_pkg::BYTE_W) - 1));
        idx[2] = lpfr_pkg::REG_END_BYTE;
        val[2] = e;
        foreach (idx[i])
        begin
            cfg_if.valid <= 1'b1;
            cfg_if.index <= idx[i];
            cfg_if.data  <= val[i];
            do @(negedge clk); while (!cfg_if.ready);
            frame_model.note_register(idx[i], val[i]);
            @(posedge clk);
        end
        cfg_if.valid <= 1'b0;
        settings_used++;
    endtask

    // payload length, mostly short
    function automatic int pick_length();
        int r;
        r = $urandom_range(19);
        if (r == 0)
            return MAX_PAYLOAD;
        else if (r < 4)
            return $urandom_range(MAX_PAYLOAD);
        else
            return $urandom_range(6);
    endfunction

    // a well formed frame with random payload
    task automatic send_good_frame(input int len);
        send_byte(frame_model.start_byte);
        send_byte(byte_t'(len));
        repeat (len) send_byte(byte_t'($urandom_range((1 << lpfr_pkg::BYTE_W) - 1)));
        send_byte(frame_model.end_byte);
    endtask

    // mostly well formed frames, the rest broken frames and noise
    task automatic send_random_sequence();
        int kind;
        int len;
        kind = $urandom_range(99);
        if (kind < 70)
            send_good_frame(pick_length());
        else if (kind < 80)
        begin
            // oversize length, sometimes equal to a high start byte
            send_byte(frame_model.start_byte);
            if (frame_model.start_byte > MAX_PAYLOAD && $urandom_range(1))
                send_byte(frame_model.start_byte);
            else
                send_byte(byte_t'($urandom_range(MAX_PAYLOAD + 1,
                                                 (1 << lpfr_pkg::BYTE_W) - 1)));
        end
        else if (kind < 90)
        begin
            // wrong end byte
            len = $urandom_range(6);
            send_byte(frame_model.start_byte);
            send_byte(byte_t'(len));
            repeat (len) send_byte(byte_t'($urandom_range((1 << lpfr_pkg::BYTE_W) - 1)));
            send_byte(frame_model.end_byte ^
                      byte_t'($urandom_range(1, (1 << lpfr_pkg::BYTE_W) - 1)));
        end
        else
            send_byte(byte_t'($urandom_range((1 << lpfr_pkg::BYTE_W) - 1)));
    endtask

    task automatic run_random_phase(input int budget, input bit mid_pause);
        int phase_start;
        bit paused;
        phase_start = link_bytes_sent;
        paused      = 1'b0;
        while (link_bytes_sent - phase_start < budget)
        begin
            send_random_sequence();
            if (mid_pause && !paused && link_bytes_sent - phase_start >= budget / 2)
            begin
                settle_link();
                paused = 1'b1;
            end
        end
    endtask

    // stimulus
    initial
    begin
        logic [lpfr_pkg::BYTE_W-1:0] directed_bytes [21];

        // zero length, one byte of extremes, oversize lengths, start byte
        // as data, wrong end byte that equals the start byte, then bytes
        // that must be ignored while hunting
        directed_bytes = '{
            lpfr_pkg::START_BYTE_RESET, 8'h00, lpfr_pkg::END_BYTE_RESET,
            lpfr_pkg::START_BYTE_RESET, 8'h01, 8'hFF, lpfr_pkg::END_BYTE_RESET,
            lpfr_pkg::START_BYTE_RESET, 8'hFF,
            lpfr_pkg::START_BYTE_RESET, 8'd64,
            lpfr_pkg::START_BYTE_RESET, lpfr_pkg::START_BYTE_RESET,
            lpfr_pkg::START_BYTE_RESET, lpfr_pkg::START_BYTE_RESET,
            lpfr_pkg::END_BYTE_RESET,
            lpfr_pkg::START_BYTE_RESET, 8'h00, lpfr_pkg::START_BYTE_RESET,
            8'h00, lpfr_pkg::END_BYTE_RESET
        };

        frame_model     = new();
        link_bytes_sent = 0;
        settings_used   = 1;
        tx_idle_pct     = 33;
        rx_idle_pct     = 87;
        rst_n           <= 1'b0;
        link_if.valid   <= 1'b0;
        link_if.in_byte <= '0;
        cfg_if.valid    <= 1'b0;
        cfg_if.index    <= '0;
        cfg_if.data     <= '0;
        frame_if.ready  <= 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed part at reset framing
        foreach (directed_bytes[i])
            send_byte(directed_bytes[i]);
        settle_link();

        // extreme framing, slow receiver
        write_framing(8'h00, 8'hFF);
        run_random_phase(PHASE_BYTES, 1'b0);
        settle_link();

        // opposite extremes, slow sender, pause halfway
        tx_idle_pct = 87;
        rx_idle_pct = 33;
        write_framing(8'hFF, 8'h00);
        run_random_phase(PHASE_BYTES, 1'b1);
        settle_link();

        // random high start byte, no idling, one frame of maximum length
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        write_framing(byte_t'($urandom_range(MAX_PAYLOAD + 1, (1 << lpfr_pkg::BYTE_W) - 1)),
                      byte_t'($urandom_range((1 << lpfr_pkg::BYTE_W) - 1)));
        send_good_frame(MAX_PAYLOAD);
        run_random_phase(PHASE_BYTES, 1'b0);
        settle_link();

        $display("covered %0d link bytes under %0d framing settings and three idle mixes",
                 link_bytes_sent, settings_used);
        $display("checked %0d frames, %0d frame bytes, %0d errors",
                 frame_model.frames_checked, frame_model.bytes_checked,
                 frame_model.error_count);
        if (frame_model.error_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

>>> length_prefixed_frame_receiver.f
+incdir+rtl
rtl/lpfr_pkg.sv
rtl/lpfr_if.sv
rtl/lpfr_ctrl.sv
rtl/lpfr_datapath.sv
rtl/length_prefixed_frame_receiver.sv
rtl/lpfr_checker.sv
tb/length_prefixed_frame_receiver_tb.sv
